// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define LSD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/lsd_pkg.sv -----
`default_nettype none

package lsd_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 16;
  localparam int ANGLE_SCALE_BITS    = 48;
  localparam int ANGLE_W             = 20;
  localparam int MAG_W               = 15;
  localparam int DIST_W              = 16;
  localparam int MULT_LO_W           = 20;
  localparam int MULT_HI_W           = 17;
  localparam int PLO_W               = MAG_W + MULT_LO_W;
  localparam int PHI_W               = MAG_W + MULT_HI_W;

  // pi/45 scaled by 2^40, applied to the angle in 1/64 degree
  localparam logic [MULT_LO_W+MULT_HI_W-1:0] ANGLE_MULT = 37'd76760392275;
  localparam logic [MULT_LO_W-1:0] ANGLE_MULT_LO = ANGLE_MULT[MULT_LO_W-1:0];
  localparam logic [MULT_HI_W-1:0] ANGLE_MULT_HI =
    ANGLE_MULT[MULT_LO_W+MULT_HI_W-1:MULT_LO_W];

  // 90 degrees in 1/64 degree
  localparam logic [16:0] ANGLE_ZERO_D = 17'd5760;

  localparam int HDR_LEN = 7;
  localparam logic [2:0] HDR_LAST = 3'(HDR_LEN - 1);

  localparam logic [2:0] IDX_FLAGS   = 3'd0;
  localparam logic [2:0] IDX_ANG_LO  = 3'd1;
  localparam logic [2:0] IDX_ANG_HI  = 3'd2;
  localparam logic [2:0] IDX_DIST_LO = 3'd3;
  localparam logic [2:0] IDX_DIST_HI = 3'd4;

  typedef enum logic {
    MODE_HUNT,
    MODE_SCAN
  } lsd_mode_t;

  typedef struct packed {
    logic [7:0]                flags_quality;
    logic signed [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]         distance;
    logic                      circle_start;
  } lsd_res_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0: b = 8'hA5;
      3'd1: b = 8'h5A;
      3'd2: b = 8'h05;
      3'd3: b = 8'h00;
      3'd4: b = 8'h00;
      3'd5: b = 8'h40;
      3'd6: b = 8'h82;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- src/lidar_scan_stream_decoder_top.sv -----
// Scan stream decoder for a laser range scanner.
// Input channel: one received byte per request on in_rx_byte, handed over
// with in_valid while in_stall is low. The block first hunts for the 7-byte
// scan-start descriptor, then gathers 5-byte samples for good.
// Output channel: one request per kept sample (flags/quality byte, angle in
// radians as signed fixed point, distance in quarter millimetres and a
// circle-start flag), handed over with out_valid while out_stall is low.
// Samples with both low flag bits clear give no request.
// Throughput: one byte per cycle unless stalled. The request shows on
// the output register in the cycle after the fifth sample byte is taken;
// the angle multiply, in two register stages, overlaps the distance bytes.
// Reset (rst_n low, synchronous) returns the block to descriptor hunting
// and empties the output register.
// Stall: the output register holds its request while out_stall is high;
// bytes keep flowing in, and only a sample's last byte is held off (in_stall)
// while the output register is full and stalled.
`default_nettype none
`include "assert_macros.svh"

module lidar_scan_stream_decoder_top #(
  parameter int ANGLE_FRAC_BITS = lsd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_rx_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_flags_quality,
  output logic signed [lsd_pkg::ANGLE_W-1:0] out_angle_rad_q16,
  output logic [lsd_pkg::DIST_W-1:0]         out_distance_qmm,
  output logic                               out_circle_start
);
  import lsd_pkg::*;

  logic               take;
  logic               samp_take;
  logic               scan_active;
  logic [2:0]         idx_r, idx_nxt;
  logic [7:0]         fq_r;
  logic [7:0]         b1_r;
  logic [7:0]         dist_lo_r;
  logic [MAG_W-1:0]   mag_r;
  logic               neg_r;
  logic [MAG_W-1:0]   raw15;
  logic [16:0]        d_w;
  logic [ANGLE_W-1:0] angle_w;
  logic               res_valid;
  lsd_res_t           res;

  assign in_stall  = out_valid && out_stall && scan_active && (idx_r == IDX_DIST_HI);
  assign take      = in_valid && !in_stall;
  assign samp_take = take && scan_active;

  lsd_hunt u_hunt (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .rx_byte     (in_rx_byte),
    .scan_active (scan_active)
  );

  always_comb begin
    idx_nxt = idx_r;
    if (samp_take) begin
      idx_nxt = (idx_r == IDX_DIST_HI) ? IDX_FLAGS : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= IDX_FLAGS;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  assign raw15 = {in_rx_byte, b1_r[7:1]};
  assign d_w   = ANGLE_ZERO_D - {2'b00, raw15};

  always_ff @(posedge clk) begin
    if (samp_take) begin
      case (idx_r)
        IDX_FLAGS:   fq_r <= in_rx_byte;
        IDX_ANG_LO:  b1_r <= in_rx_byte;
        IDX_ANG_HI: begin
          neg_r <= d_w[16];
          mag_r <= d_w[16] ? MAG_W'(17'd0 - d_w) : d_w[MAG_W-1:0];
        end
        IDX_DIST_LO: dist_lo_r <= in_rx_byte;
        default: ;
      endcase
    end
  end

  lsd_angle #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_angle (
    .clk   (clk),
    .mag   (mag_r),
    .neg   (neg_r),
    .angle (angle_w)
  );

  always_comb begin
    res_valid          = samp_take && (idx_r == IDX_DIST_HI) && (fq_r[1] || fq_r[0]);
    res.flags_quality  = fq_r;
    res.angle          = angle_w;
    res.distance       = {in_rx_byte, dist_lo_r};
    res.circle_start   = !fq_r[1] && fq_r[0];
  end

  lsd_outreg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_flags_quality (out_flags_quality),
    .out_angle_rad_q16 (out_angle_rad_q16),
    .out_distance_qmm  (out_distance_qmm),
    .out_circle_start  (out_circle_start)
  );

  `LSD_ASSERT(a_no_overrun, !(res_valid && out_valid && out_stall), "request lost on a stalled output register")
  `LSD_ASSERT(a_idx_range, idx_r <= IDX_DIST_HI, "sample byte index out of range")

endmodule

`default_nettype wire

// ----- src/lsd_hunt.sv -----
`default_nettype none
`include "assert_macros.svh"

module lsd_hunt (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       scan_active
);
  import lsd_pkg::*;

  lsd_mode_t  state_r, state_nxt;
  logic [2:0] pos_r, pos_nxt;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    case (state_r)
      MODE_HUNT: begin
        if (take) begin
          if (rx_byte == hdr_byte(pos_r)) begin
            if (pos_r == HDR_LAST) begin
              state_nxt = MODE_SCAN;
              pos_nxt   = 3'd0;
            end else begin
              pos_nxt = pos_r + 3'd1;
            end
          end else begin
            pos_nxt = 3'd0;
          end
        end
      end
      MODE_SCAN: begin
        pos_nxt = 3'd0;
      end
      default: begin
        state_nxt = MODE_HUNT;
        pos_nxt   = 3'd0;
      end
    endcase
  end

  always_comb begin
    case (state_r)
      MODE_SCAN: scan_active = 1'b1;
      default:   scan_active = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MODE_HUNT;
      pos_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  `LSD_ASSERT(a_pos_range, (pos_r <= HDR_LAST) && (state_r == MODE_HUNT || pos_r == 3'd0), "descriptor position out of range")
  `LSD_ASSERT_NEXT(a_scan_sticky, state_r == MODE_SCAN, state_r == MODE_SCAN, "scan mode left without reset")

endmodule

`default_nettype wire

// ----- src/lsd_angle.sv -----
`default_nettype none

module lsd_angle #(
  parameter int ANGLE_FRAC_BITS = lsd_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [lsd_pkg::MAG_W-1:0]         mag,
  input  logic                              neg,
  output logic signed [lsd_pkg::ANGLE_W-1:0] angle
);
  import lsd_pkg::*;

  localparam int SHIFT  = ANGLE_SCALE_BITS - ANGLE_FRAC_BITS;
  localparam int PROD_W = PHI_W + MULT_LO_W + 1;

  logic [PLO_W-1:0]  p_lo_r;
  logic [PHI_W-1:0]  p_hi_r;
  logic              neg_r;
  logic [PROD_W-1:0] sum;
  logic [PROD_W-1:0] shifted;
  logic [ANGLE_W-1:0] mag_q;

  always_ff @(posedge clk) begin
    p_lo_r <= PLO_W'(mag) * PLO_W'(ANGLE_MULT_LO);
    p_hi_r <= PHI_W'(mag) * PHI_W'(ANGLE_MULT_HI);
    neg_r  <= neg;
  end

  always_comb begin
    sum     = PROD_W'({p_hi_r, MULT_LO_W'(0)}) + PROD_W'(p_lo_r)
            + (PROD_W'(1) << (SHIFT - 1));
    shifted = sum >> SHIFT;
    mag_q   = shifted[ANGLE_W-1:0];
    angle   = neg_r ? $signed(ANGLE_W'(0) - mag_q) : $signed(mag_q);
  end

endmodule

`default_nettype wire

// ----- src/lsd_outreg.sv -----
`default_nettype none

module lsd_outreg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                res_valid,
  input  lsd_pkg::lsd_res_t                   res,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_flags_quality,
  output logic signed [lsd_pkg::ANGLE_W-1:0]  out_angle_rad_q16,
  output logic [lsd_pkg::DIST_W-1:0]          out_distance_qmm,
  output logic                                out_circle_start
);
  import lsd_pkg::*;

  logic     valid_r, valid_nxt;
  lsd_res_t res_r;
  logic     load;

  assign load = res_valid && (!valid_r || !out_stall);

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_flags_quality = res_r.flags_quality;
  assign out_angle_rad_q16 = res_r.angle;
  assign out_distance_qmm  = res_r.distance;
  assign out_circle_start  = res_r.circle_start;

endmodule

`default_nettype wire
